// ===== rtl/htwc_pkg.sv =====
// Shared types and constants for the hysteresis-triggered window capture block.
// Depends on nothing; every other file in rtl imports it.
`default_nettype none

package htwc_pkg;

    localparam int CHANNELS       = 6;
    localparam int CH_TRIGGER     = 1;
    localparam int SLOT_BITS      = 6;
    localparam int FILL_BITS      = 7;
    localparam int RING_PTR_BITS  = 5;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTER_LEVEL      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXIT_LEVEL       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTER_WHEN_ABOVE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_GATE       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COOLDOWN_MS      = 3'd4;

    localparam logic signed [15:0] ENTER_LEVEL_RESET = 16'sd896;
    localparam logic signed [15:0] EXIT_LEVEL_RESET  = 16'sd1152;
    localparam logic signed [15:0] DEPTH_GATE_RESET  = 16'sd384;
    localparam logic [15:0]        COOLDOWN_RESET    = 16'd800;

    typedef logic signed [15:0] q88_t;

    // Write strobes from the front end into the back end's storage.
    typedef struct packed {
        logic                     ring_we;
        logic [RING_PTR_BITS-1:0] ring_idx;
        logic                     mem_we;
        logic [SLOT_BITS-1:0]     mem_idx;
    } store_wr_t;

    // One counted event waiting to be played out.
    typedef struct packed {
        logic [7:0]               evt;
        logic [FILL_BITS-1:0]     fill;
        logic [RING_PTR_BITS-1:0] base;
    } job_t;

endpackage

`default_nettype wire

// ===== rtl/htwc_front.sv =====
// Front end: takes samples, keeps the pre-trigger write pointer, arms and exits
// on the trigger channel, judges each event and queues counted ones. Uses htwc_pkg.
`default_nettype none

module htwc_front #(
    parameter int WINDOW_LEN  = 50,
    parameter int PRE_LEN     = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire logic                                              cfg_we,
    input  wire logic [htwc_pkg::CFG_INDEX_BITS-1:0]               cfg_index,
    input  wire logic [htwc_pkg::CFG_DATA_BITS-1:0]                cfg_data,
    input  wire logic                                              take,
    input  wire logic [htwc_pkg::CHANNELS-1:0][15:0]               sample,
    input  wire logic [31:0]                                       stamp_ms,
    output htwc_pkg::store_wr_t                                    wr,
    output logic [htwc_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0]         wr_data,
    output logic                                                   push,
    output htwc_pkg::job_t                                         push_job
);
    import htwc_pkg::*;

    localparam int FW    = $clog2(WINDOW_LEN + 1);
    localparam int RW    = (PRE_LEN > 1) ? $clog2(PRE_LEN) : 1;
    localparam int NSEED = (PRE_LEN < WINDOW_LEN) ? PRE_LEN : WINDOW_LEN;

    logic signed [15:0] enter_level_reg;
    logic signed [15:0] exit_level_reg;
    logic               enter_above_reg;
    logic signed [15:0] depth_gate_reg;
    logic [15:0]        cooldown_reg;

    logic               armed_reg;
    logic [RW-1:0]      wr_ptr_reg;
    logic [RW-1:0]      wr_ptr_next;
    logic [RW-1:0]      base_reg;
    logic [FW-1:0]      fill_reg;
    logic [FW-1:0]      fill_next;
    logic signed [15:0] lowest_reg;
    logic signed [15:0] lowest_next;
    logic [31:0]        last_ms_reg;
    logic [7:0]         count_reg;

    q88_t               ay;
    logic               hit;
    logic               exit_hit;
    logic               room;
    logic [31:0]        elapsed;
    logic               counts;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            wr_data[c] = SAMPLE_BITS'(signed'(sample[c]));
        end
    end

    assign ay          = signed'(sample[CH_TRIGGER]);
    assign wr_ptr_next = (wr_ptr_reg == RW'(PRE_LEN - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign hit         = enter_above_reg ? (ay > enter_level_reg) : (ay < enter_level_reg);
    assign exit_hit    = enter_above_reg ? (ay < exit_level_reg) : (ay > exit_level_reg);
    assign lowest_next = (ay < lowest_reg) ? ay : lowest_reg;
    assign room        = fill_reg < FW'(WINDOW_LEN);
    assign fill_next   = room ? fill_reg + 1'b1 : fill_reg;
    // The subtraction wraps modulo two to the 32, as the stamp does.
    assign elapsed     = stamp_ms - last_ms_reg;
    assign counts      = (elapsed > {16'd0, cooldown_reg}) && (lowest_next < depth_gate_reg);

    always_comb
    begin
        wr.ring_we  = take && !armed_reg;
        wr.ring_idx = RING_PTR_BITS'(wr_ptr_reg);
        wr.mem_we   = take && armed_reg && room;
        wr.mem_idx  = SLOT_BITS'(fill_reg);
    end

    assign push          = take && armed_reg && exit_hit && counts;
    assign push_job.evt  = count_reg + 8'd1;
    assign push_job.fill = FILL_BITS'(fill_next);
    assign push_job.base = RING_PTR_BITS'(base_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_level_reg <= ENTER_LEVEL_RESET;
            exit_level_reg  <= EXIT_LEVEL_RESET;
            enter_above_reg <= 1'b0;
            depth_gate_reg  <= DEPTH_GATE_RESET;
            cooldown_reg    <= COOLDOWN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENTER_LEVEL:      enter_level_reg <= signed'(cfg_data);
                REG_EXIT_LEVEL:       exit_level_reg  <= signed'(cfg_data);
                REG_ENTER_WHEN_ABOVE: enter_above_reg <= cfg_data[0];
                REG_DEPTH_GATE:       depth_gate_reg  <= signed'(cfg_data);
                REG_COOLDOWN_MS:      cooldown_reg    <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            wr_ptr_reg  <= '0;
            base_reg    <= '0;
            fill_reg    <= '0;
            lowest_reg  <= '0;
            last_ms_reg <= '0;
            count_reg   <= '0;
        end
        else if (take)
        begin
            if (!armed_reg)
            begin
                wr_ptr_reg <= wr_ptr_next;
                if (hit)
                begin
                    // The slot after the one just written holds the oldest sample.
                    armed_reg  <= 1'b1;
                    base_reg   <= wr_ptr_next;
                    fill_reg   <= FW'(NSEED);
                    lowest_reg <= ay;
                end
            end
            else if (exit_hit)
            begin
                armed_reg  <= 1'b0;
                fill_reg   <= '0;
                lowest_reg <= lowest_next;
                if (counts)
                begin
                    count_reg   <= count_reg + 8'd1;
                    last_ms_reg <= stamp_ms;
                end
            end
            else
            begin
                fill_reg   <= fill_next;
                lowest_reg <= lowest_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/htwc_queue.sv =====
// Two-entry queue of counted events between the front and back ends.
// Uses htwc_pkg for the event descriptor.
`default_nettype none

module htwc_queue #(
    parameter int PAD_W = 96
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire htwc_pkg::job_t   push_job,
    input  wire logic [PAD_W-1:0] push_pad,
    input  wire logic             pop,
    output logic                  nonempty,
    output htwc_pkg::job_t        head_job,
    output logic [PAD_W-1:0]      head_pad
);
    import htwc_pkg::*;

    localparam int DEPTH = 2;

    job_t             job_reg [DEPTH];
    logic [PAD_W-1:0] pad_reg [DEPTH];
    logic             head_reg;
    logic             tail_reg;
    logic [1:0]       count_reg;

    assign nonempty = count_reg != 2'd0;
    assign head_job = job_reg[head_reg];
    assign head_pad = pad_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_reg[tail_reg] <= push_job;
            pad_reg[tail_reg] <= push_pad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= !tail_reg;
            end
            if (pop)
            begin
                head_reg <= !head_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != 2'd2)
        else $error("event queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("event queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/htwc_back.sv =====
// Back end: holds the pre-trigger ring and the capture memory, and plays a
// counted event out slot by slot through a read stage and an output register.
// Uses htwc_pkg.
`default_nettype none

module htwc_back #(
    parameter int WINDOW_LEN  = 50,
    parameter int PRE_LEN     = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire htwc_pkg::store_wr_t                           wr,
    input  wire logic [htwc_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] wr_data,
    input  wire logic                                          job_valid,
    input  wire htwc_pkg::job_t                                job,
    input  wire logic [htwc_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] job_pad,
    output logic                                               job_pop,
    output logic                                               busy,
    input  wire logic                                          out_ready,
    output logic                                               out_valid,
    output logic [htwc_pkg::CHANNELS-1:0][15:0]                out_sample,
    output logic [htwc_pkg::SLOT_BITS-1:0]                     out_slot,
    output logic [7:0]                                         out_evt,
    output logic                                               out_last
);
    import htwc_pkg::*;

    localparam int MW    = $clog2(WINDOW_LEN);
    localparam int RW    = (PRE_LEN > 1) ? $clog2(PRE_LEN) : 1;
    localparam int NSEED = (PRE_LEN < WINDOW_LEN) ? PRE_LEN : WINDOW_LEN;

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] row_t;

    row_t ring_reg [PRE_LEN];
    row_t mem [WINDOW_LEN];

    logic           busy_reg;
    logic [MW-1:0]  slot_reg;
    logic [RW-1:0]  rp_reg;
    job_t           job_reg;
    row_t           pad_reg;

    logic           s1_valid_reg;
    logic           s1_mem_reg;
    row_t           s1_data_reg;
    row_t           mem_rd_reg;
    logic [MW-1:0]  s1_slot_reg;
    logic [7:0]     s1_evt_reg;
    logic           s1_last_reg;

    logic           out_valid_reg;
    row_t           out_data_reg;
    logic [MW-1:0]  out_slot_reg;
    logic [7:0]     out_evt_reg;
    logic           out_last_reg;

    logic           out_load;
    logic           issue;
    logic           is_last;
    logic           from_ring;
    logic           from_mem;

    assign busy      = busy_reg;
    assign job_pop   = job_valid && !busy_reg;
    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign issue     = busy_reg && (!s1_valid_reg || out_load);
    assign is_last   = slot_reg == MW'(WINDOW_LEN - 1);
    // Seeded slots come from the ring, captured ones from memory, the rest are padding.
    assign from_ring = FILL_BITS'(slot_reg) < FILL_BITS'(NSEED);
    assign from_mem  = !from_ring && (FILL_BITS'(slot_reg) < job_reg.fill);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < PRE_LEN; e++)
            begin
                ring_reg[e] <= '0;
            end
        end
        else if (wr.ring_we)
        begin
            ring_reg[wr.ring_idx[RW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.mem_we)
        begin
            mem[wr.mem_idx[MW-1:0]] <= wr_data;
        end
        if (issue)
        begin
            mem_rd_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
            pad_reg <= job_pad;
        end
        if (issue)
        begin
            s1_mem_reg  <= from_mem;
            s1_data_reg <= from_ring ? ring_reg[rp_reg] : pad_reg;
            s1_slot_reg <= slot_reg;
            s1_evt_reg  <= job_reg.evt;
            s1_last_reg <= is_last;
        end
        if (out_load)
        begin
            out_data_reg <= s1_mem_reg ? mem_rd_reg : s1_data_reg;
            out_slot_reg <= s1_slot_reg;
            out_evt_reg  <= s1_evt_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= '0;
            rp_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_pop)
            begin
                busy_reg <= 1'b1;
                slot_reg <= '0;
                rp_reg   <= job.base[RW-1:0];
            end
            else if (issue)
            begin
                slot_reg <= slot_reg + 1'b1;
                rp_reg   <= (rp_reg == RW'(PRE_LEN - 1)) ? '0 : rp_reg + 1'b1;
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            out_sample[c] = 16'(signed'(out_data_reg[c]));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = SLOT_BITS'(out_slot_reg);
    assign out_evt   = out_evt_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_slot_reg == MW'(WINDOW_LEN - 1))
        else $error("end of window flagged on the wrong slot");

    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> slot_reg == '0)
        else $error("window playback did not start at slot zero");
`endif

endmodule

`default_nettype wire

// ===== rtl/hysteresis_triggered_window_capture.sv =====
// Top level of the hysteresis-triggered window capture block: front end,
// event queue and back end. Depends on htwc_pkg, htwc_front, htwc_queue, htwc_back.
//
//   Port group  Handshake            Beat
//   cfg         cfg_we               cfg_index, cfg_data
//   in          in_valid / in_ready  accel_x .. rate_z, stamp_ms
//   out         out_valid / out_ready out_accel_x .. out_rate_z, slot_index,
//                                    event_number, last_of_window
//
// While idle or capturing, one sample is taken every cycle that in_valid is high.
// A counted event holds the input off while it moves from the queue into playback
// and while its WINDOW_LEN slots are issued, one a cycle unless a slot waits because
// out_ready is low while the read and output registers are both full.
// Each beat passes from the read stage through the output register to the out port.
// Reset clears the pre-trigger ring in flops at once; there is no clearing pass.
// After the last slot is issued, a beat waiting on the output does not block input.
`default_nettype none

module hysteresis_triggered_window_capture #(
    parameter int WINDOW_LEN  = 50,
    parameter int PRE_LEN     = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [htwc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [htwc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [15:0]                    accel_x,
    input  wire logic signed [15:0]                    accel_y,
    input  wire logic signed [15:0]                    accel_z,
    input  wire logic signed [15:0]                    rate_x,
    input  wire logic signed [15:0]                    rate_y,
    input  wire logic signed [15:0]                    rate_z,
    input  wire logic [31:0]                           stamp_ms,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [15:0]                         out_accel_x,
    output logic signed [15:0]                         out_accel_y,
    output logic signed [15:0]                         out_accel_z,
    output logic signed [15:0]                         out_rate_x,
    output logic signed [15:0]                         out_rate_y,
    output logic signed [15:0]                         out_rate_z,
    output logic [htwc_pkg::SLOT_BITS-1:0]             slot_index,
    output logic [7:0]                                 event_number,
    output logic                                       last_of_window
);
    import htwc_pkg::*;

    localparam int PAD_W = CHANNELS * SAMPLE_BITS;

    logic [CHANNELS-1:0][15:0]          sample;
    logic [CHANNELS-1:0][15:0]          out_sample;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] wr_data;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] head_pad;
    store_wr_t                          wr;
    job_t                               push_job;
    job_t                               head_job;
    logic                               push;
    logic                               pop;
    logic                               nonempty;
    logic                               busy;
    logic                               take;

    // The ring and memory are shared with playback, so sampling waits for it.
    assign in_ready = !nonempty && !busy;
    assign take     = in_valid && in_ready;

    assign sample[0] = accel_x;
    assign sample[1] = accel_y;
    assign sample[2] = accel_z;
    assign sample[3] = rate_x;
    assign sample[4] = rate_y;
    assign sample[5] = rate_z;

    htwc_front #(
        .WINDOW_LEN (WINDOW_LEN),
        .PRE_LEN    (PRE_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .take     (take),
        .sample   (sample),
        .stamp_ms (stamp_ms),
        .wr       (wr),
        .wr_data  (wr_data),
        .push     (push),
        .push_job (push_job)
    );

    htwc_queue #(
        .PAD_W(PAD_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .push_pad(wr_data),
        .pop     (pop),
        .nonempty(nonempty),
        .head_job(head_job),
        .head_pad(head_pad)
    );

    htwc_back #(
        .WINDOW_LEN (WINDOW_LEN),
        .PRE_LEN    (PRE_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .wr_data   (wr_data),
        .job_valid (nonempty),
        .job       (head_job),
        .job_pad   (head_pad),
        .job_pop   (pop),
        .busy      (busy),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_sample(out_sample),
        .out_slot  (slot_index),
        .out_evt   (event_number),
        .out_last  (last_of_window)
    );

    assign out_accel_x = signed'(out_sample[0]);
    assign out_accel_y = signed'(out_sample[1]);
    assign out_accel_z = signed'(out_sample[2]);
    assign out_rate_x  = signed'(out_sample[3]);
    assign out_rate_y  = signed'(out_sample[4]);
    assign out_rate_z  = signed'(out_sample[5]);

endmodule

`default_nettype wire
